// ----- rtl/cht_pkg.sv -----
package cht_pkg;

   localparam int KEY_W = 64;
   localparam int VAL_W = 32;
   localparam int CFG_W = 11;

   localparam logic [1:0] REQ_PUT    = 2'd0;
   localparam logic [1:0] REQ_GET    = 2'd1;
   localparam logic [1:0] REQ_HAS    = 2'd2;
   localparam logic [1:0] REQ_REMOVE = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DUP       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_POOL_FULL = 2'd3;

   localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 11'd1024;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value_in;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [VAL_W-1:0] value_out;
   } rsp_word_type;

endpackage

// ----- rtl/cht_ram.sv -----
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/cht_front.sv -----
module cht_front #(
   parameter int BUCKETS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic [cht_pkg::CFG_W-1:0]     bucket_count,
   input  logic                          req_push,
   output logic                          req_full,
   input  cht_pkg::req_word_type         req_word,
   output logic                          q_valid,
   input  logic                          q_pop,
   output cht_pkg::req_word_type         q_word,
   output logic [$clog2(BUCKETS)-1:0]    q_bucket
);
   import cht_pkg::*;

   localparam int HB = $clog2(BUCKETS);
   localparam int RW = $clog2(BUCKETS + 1);

   logic              busy_ff, busy_in;
   logic              pend_ff, pend_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [KEY_W-1:0]  ksh_ff, ksh_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     bc_ff, bc_in;
   req_word_type      word_ff, word_in;
   logic [RW:0]       trial;
   logic [RW-1:0]     bc_eff;
   logic              accept;
   logic              q_push;

   req_word_type      qw_ff [2];
   logic [HB-1:0]     qb_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        qc_ff;

   always_comb begin
      if (bucket_count == '0) begin
         bc_eff = RW'(1);
      end else if (32'(bucket_count) > BUCKETS) begin
         bc_eff = RW'(BUCKETS);
      end else begin
         bc_eff = RW'(bucket_count);
      end
   end

   assign req_full = busy_ff | pend_ff | hold;
   assign accept   = req_push & ~req_full;
   assign q_push   = pend_ff & (qc_ff != 2'd2);
   assign trial    = {rem_ff, ksh_ff[KEY_W-1]};

   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      ksh_in  = ksh_ff;
      rem_in  = rem_ff;
      bc_in   = bc_ff;
      word_in = word_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ksh_in  = req_word.key;
         rem_in  = '0;
         bc_in   = bc_eff;
         word_in = req_word;
      end else if (busy_ff) begin
         if (trial >= {1'b0, bc_ff}) begin
            rem_in = RW'(trial - {1'b0, bc_ff});
         end else begin
            rem_in = RW'(trial);
         end
         ksh_in = ksh_ff << 1;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            pend_in = 1'b1;
         end
      end else if (q_push) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         qc_ff   <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         if (q_push) begin
            wp_ff <= ~wp_ff;
         end
         if (q_pop) begin
            rp_ff <= ~rp_ff;
         end
         qc_ff <= qc_ff + {1'b0, q_push} - {1'b0, q_pop};
      end
      cnt_ff  <= cnt_in;
      ksh_ff  <= ksh_in;
      rem_ff  <= rem_in;
      bc_ff   <= bc_in;
      word_ff <= word_in;
      if (q_push) begin
         qw_ff[wp_ff] <= word_ff;
         qb_ff[wp_ff] <= rem_ff[HB-1:0];
      end
   end

   assign q_valid  = qc_ff != 2'd0;
   assign q_word   = qw_ff[rp_ff];
   assign q_bucket = qb_ff[rp_ff];

endmodule

// ----- rtl/cht_back.sv -----
module cht_back #(
   parameter int BUCKETS    = 1024,
   parameter int NODES      = 512,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          clearing,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  cht_pkg::req_word_type         q_word,
   input  logic [$clog2(BUCKETS)-1:0]    q_bucket,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output cht_pkg::rsp_word_type         rsp_word
);
   import cht_pkg::*;

   localparam int HB  = $clog2(BUCKETS);
   localparam int NW  = $clog2(NODES);
   localparam int LW  = $clog2(NODES + 1);
   localparam int CW  = $clog2(NODES + 1);
   localparam int SVB = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
   localparam int EW  = KEY_W + SVB + LW;

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HEAD  = 3'd2;
   localparam logic [2:0] S_NODE  = 3'd3;
   localparam logic [2:0] S_ALLOC = 3'd4;
   localparam logic [2:0] S_LINK  = 3'd5;
   localparam logic [2:0] S_PULL  = 3'd6;

   logic [2:0]        st_ff, st_in;
   logic [HB-1:0]     clr_ff, clr_in;
   logic [1:0]        rt_ff, rt_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SVB-1:0]    val_ff, val_in;
   logic [HB-1:0]     bkt_ff, bkt_in;
   logic [KEY_W-1:0]  hk_ff, hk_in;
   logic [SVB-1:0]    hv_ff, hv_in;
   logic [LW-1:0]     hl_ff, hl_in;
   logic [LW-1:0]     cur_ff, cur_in;
   logic [LW-1:0]     prev_ff, prev_in;
   logic [EW-1:0]     pw_ff, pw_in;
   logic [NW-1:0]     new_ff, new_in;
   logic [CW-1:0]     free_ff, free_in;
   logic [CW-1:0]     low_ff, low_in;
   logic              rv_ff, rv_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic              h_we, n_we, s_we;
   logic [HB-1:0]     h_wa, h_ra;
   logic [NW-1:0]     n_wa, n_ra, s_wa, s_ra;
   logic [EW-1:0]     h_wd, n_wd, h_rd, n_rd;
   logic [NW-1:0]     s_wd, s_rd;

   logic [KEY_W-1:0]  rk;
   logic [SVB-1:0]    rvv;
   logic [LW-1:0]     rl;
   logic              fin, miss, rel;
   logic [1:0]        fin_st;
   logic              fin_fd;
   logic [SVB-1:0]    fin_v;
   logic [NW-1:0]     rel_n, alloc_n;

   cht_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
      .clock(clock), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
   );
   cht_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node (
      .clock(clock), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
   );
   cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stack (
      .clock(clock), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
   );

   assign clearing = st_ff == S_CLR;
   assign q_pop    = (st_ff == S_IDLE) & q_valid & ~rv_ff;
   assign alloc_n  = (free_ff <= low_ff) ? NW'(CW'(NODES) - free_ff) : s_rd;

   always_comb begin
      st_in   = st_ff;
      clr_in  = clr_ff;
      rt_in   = rt_ff;
      key_in  = key_ff;
      val_in  = val_ff;
      bkt_in  = bkt_ff;
      hk_in   = hk_ff;
      hv_in   = hv_ff;
      hl_in   = hl_ff;
      cur_in  = cur_ff;
      prev_in = prev_ff;
      pw_in   = pw_ff;
      new_in  = new_ff;
      free_in = free_ff;
      low_in  = low_ff;
      rv_in   = rv_ff & ~rsp_pop;
      rsp_in  = rsp_ff;
      h_we = 1'b0; h_wa = bkt_ff; h_wd = '0; h_ra = q_bucket;
      n_we = 1'b0; n_wa = '0;     n_wd = '0; n_ra = '0;
      s_we = 1'b0; s_wa = NW'(free_ff); s_wd = '0;
      s_ra = NW'(free_ff - CW'(1));
      fin = 1'b0; miss = 1'b0; rel = 1'b0;
      fin_st = ST_DONE; fin_fd = 1'b0; fin_v = '0; rel_n = '0;
      rk  = (st_ff == S_HEAD) ? h_rd[EW-1 -: KEY_W] : n_rd[EW-1 -: KEY_W];
      rvv = (st_ff == S_HEAD) ? h_rd[LW +: SVB]     : n_rd[LW +: SVB];
      rl  = (st_ff == S_HEAD) ? h_rd[LW-1:0]        : n_rd[LW-1:0];

      case (st_ff)
         S_CLR: begin
            h_we = 1'b1;
            h_wa = clr_ff;
            clr_in = clr_ff + HB'(1);
            if (32'(clr_ff) == BUCKETS - 1) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_pop) begin
               rt_in  = q_word.req_type;
               key_in = q_word.key;
               val_in = SVB'(q_word.value_in);
               bkt_in = q_bucket;
               st_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            hk_in = rk; hv_in = rvv; hl_in = rl;
            prev_in = '0;
            if (key_ff == '0) begin
               fin = 1'b1;
               fin_st = (rt_ff == REQ_PUT) ? ST_DONE : ST_NOT_FOUND;
            end else if (rk == '0) begin
               fin = 1'b1;
               if (rt_ff == REQ_PUT) begin
                  h_we = 1'b1;
                  h_wd = {key_ff, val_ff, LW'(0)};
               end else begin
                  fin_st = ST_NOT_FOUND;
               end
            end else if (rk == key_ff) begin
               case (rt_ff)
                  REQ_PUT: begin
                     fin = 1'b1; fin_st = ST_DUP;
                  end
                  REQ_GET: begin
                     fin = 1'b1; fin_fd = 1'b1; fin_v = rvv;
                  end
                  REQ_HAS: begin
                     fin = 1'b1; fin_fd = 1'b1;
                  end
                  default: begin
                     if (rl != '0) begin
                        n_ra = NW'(rl - LW'(1));
                        st_in = S_PULL;
                     end else begin
                        h_we = 1'b1;
                        fin = 1'b1;
                     end
                  end
               endcase
            end else if (rl == '0) begin
               miss = 1'b1;
            end else begin
               n_ra = NW'(rl - LW'(1));
               cur_in = rl;
               st_in = S_NODE;
            end
         end
         S_NODE: begin
            if (rk == key_ff) begin
               case (rt_ff)
                  REQ_PUT: begin
                     fin = 1'b1; fin_st = ST_DUP;
                  end
                  REQ_GET: begin
                     fin = 1'b1; fin_fd = 1'b1; fin_v = rvv;
                  end
                  REQ_HAS: begin
                     fin = 1'b1; fin_fd = 1'b1;
                  end
                  default: begin
                     if (prev_ff == '0) begin
                        h_we = 1'b1;
                        h_wd = {hk_ff, hv_ff, rl};
                     end else begin
                        n_we = 1'b1;
                        n_wa = NW'(prev_ff - LW'(1));
                        n_wd = {pw_ff[EW-1:LW], rl};
                     end
                     rel = 1'b1;
                     rel_n = NW'(cur_ff - LW'(1));
                     fin = 1'b1;
                  end
               endcase
            end else begin
               prev_in = cur_ff;
               pw_in = n_rd;
               if (rl == '0) begin
                  miss = 1'b1;
               end else begin
                  n_ra = NW'(rl - LW'(1));
                  cur_in = rl;
               end
            end
         end
         S_ALLOC: begin
            free_in = free_ff - CW'(1);
            if (free_ff - CW'(1) < low_ff) begin
               low_in = free_ff - CW'(1);
            end
            new_in = alloc_n;
            n_we = 1'b1;
            n_wa = alloc_n;
            n_wd = {key_ff, val_ff, LW'(0)};
            if (prev_ff == '0) begin
               h_we = 1'b1;
               h_wd = {hk_ff, hv_ff, LW'(alloc_n) + LW'(1)};
               fin = 1'b1;
            end else begin
               st_in = S_LINK;
            end
         end
         S_LINK: begin
            n_we = 1'b1;
            n_wa = NW'(prev_ff - LW'(1));
            n_wd = {pw_ff[EW-1:LW], LW'(new_ff) + LW'(1)};
            fin = 1'b1;
         end
         S_PULL: begin
            h_we = 1'b1;
            h_wd = n_rd;
            rel = 1'b1;
            rel_n = NW'(hl_ff - LW'(1));
            fin = 1'b1;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (miss) begin
         if (rt_ff != REQ_PUT) begin
            fin = 1'b1; fin_st = ST_NOT_FOUND;
         end else if (free_ff == '0) begin
            fin = 1'b1; fin_st = ST_POOL_FULL;
         end else begin
            st_in = S_ALLOC;
         end
      end
      if (rel && (32'(free_ff) < NODES)) begin
         s_we = 1'b1;
         s_wd = rel_n;
         free_in = free_ff + CW'(1);
      end
      if (fin) begin
         st_in = S_IDLE;
         rv_in = 1'b1;
         rsp_in.status    = fin_st;
         rsp_in.found     = fin_fd;
         rsp_in.value_out = VAL_W'(fin_v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_CLR;
         clr_ff  <= '0;
         free_ff <= CW'(NODES);
         low_ff  <= CW'(NODES);
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         clr_ff  <= clr_in;
         free_ff <= free_in;
         low_ff  <= low_in;
         rv_ff   <= rv_in;
      end
      rt_ff   <= rt_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      bkt_ff  <= bkt_in;
      hk_ff   <= hk_in;
      hv_ff   <= hv_in;
      hl_ff   <= hl_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      pw_ff   <= pw_in;
      new_ff  <= new_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_empty = ~rv_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- rtl/chained_hash_table_engine_unit.sv -----
// Hash map from 64-bit keys to value handles with separate chaining. The front
// computes key mod bucket_count one bit per cycle and queues up to two
// classified words; the back walks the bucket head and its chain, with
// further steps for an insert or a removal. Sustained rate is set by the
// serial modulo while chains stay under about 60 nodes; longer chains make the
// back walk set the rate. After reset the head memory is swept clear with
// req_full held high. Key zero is never stored or found.
module chained_hash_table_engine_unit #(
   parameter int BUCKETS    = 1024,
   parameter int NODES      = 512,
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  cht_pkg::req_word_type     req_word,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output cht_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_write_en,
   input  logic [cht_pkg::CFG_W-1:0] csr_write_data
);
   import cht_pkg::*;

   logic [CFG_W-1:0]           bucket_count_ff;
   logic                       clearing;
   logic                       q_valid, q_pop;
   req_word_type               q_word;
   logic [$clog2(BUCKETS)-1:0] q_bucket;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else if (csr_write_en) begin
         bucket_count_ff <= csr_write_data;
      end
   end

   cht_front #(.BUCKETS(BUCKETS)) u_front (
      .clock(clock), .reset(reset), .hold(clearing), .bucket_count(bucket_count_ff),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word), .q_bucket(q_bucket)
   );

   cht_back #(.BUCKETS(BUCKETS), .NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock(clock), .reset(reset), .clearing(clearing),
      .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word), .q_bucket(q_bucket),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word)
   );

endmodule

// ----- rtl/cht_checker.sv -----
module cht_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input cht_pkg::rsp_word_type     rsp_word
);
   import cht_pkg::*;

   a_clear_blocks: assert property (@(posedge clock) reset |=> req_full && rsp_empty)
      else $error("input open or result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting result changed");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.found |-> rsp_word.status == ST_DONE)
      else $error("found with error status");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_word.found |-> rsp_word.value_out == '0)
      else $error("value without found");

endmodule

bind chained_hash_table_engine_unit cht_checker u_cht_checker (.*);
